FILE: rtl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// shared types and constants of the stack machine execute unit
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned CountW = 9;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,
        OP_POP   = 5'd1,
        OP_SWAP  = 5'd2,
        OP_DUP   = 5'd3,
        OP_ADD   = 5'd4,
        OP_SUB   = 5'd5,
        OP_MUL   = 5'd6,
        OP_DIV   = 5'd7,
        OP_MOD   = 5'd8,
        OP_XOR   = 5'd9,
        OP_OR    = 5'd10,
        OP_AND   = 5'd11,
        OP_NOT   = 5'd12,
        OP_SHR   = 5'd13,
        OP_SHL   = 5'd14,
        OP_LABEL = 5'd15,
        OP_JMP   = 5'd16,
        OP_JE    = 5'd17,
        OP_JNE   = 5'd18,
        OP_JGE   = 5'd19,
        OP_JLE   = 5'd20,
        OP_PRINT = 5'd21
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef struct packed {
        logic [4:0]         cmd;
        logic signed [31:0] immediate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [8:0]         stack_count;
        logic               branch_taken;
        logic               print_request;
        logic [1:0]         status;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture instruction
        logic rd_top;    // read top entry
        logic rd_sec;    // read second entry
        logic exec;      // evaluate, start divider if needed
        logic commit;    // write back and form result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
    } t_sts;

endpackage

FILE: rtl/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// execute stage of a 32-bit integer stack machine
// ----------------------------------------------------------------------------
// usage: one instruction (cmd, immediate) enters on the input channel when
// i_in_valid is high and o_in_stall is low; exactly one result leaves on the
// output channel, valid until a transfer with i_out_stall low.
// sequence: load, read top, read second, evaluate, wait for the divider
// on div and mod (bit-serial), commit, then offer the result.
// the single-port stack memory read (top, then second) and the divider set
// this pace; one instruction is in flight at a time, so the next input
// transfer comes only after the previous result has transferred.
// reset: synchronous active-low i_rst_n empties the stack; memory contents
// are not cleared and need no clearing pass.
// a stalled result holds its value and the input stays stalled until the
// result transfers.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit #(
    parameter int unsigned STACK_WORDS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  smeu_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output smeu_pkg::t_out_item o_out_data
);
    import smeu_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    smeu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    smeu_datapath #(
        .STACK_WORDS (STACK_WORDS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_data),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts),
        .o_result (o_out_data)
    );
endmodule

FILE: rtl/smeu_div.sv
// ----------------------------------------------------------------------------
// smeu_div
// radix-2 restoring divider on magnitudes, one quotient bit per cycle
// ----------------------------------------------------------------------------
module smeu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic [31:0] r_quot;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    assign n_shift = {r_rem, r_quot[31]};
    assign n_trial = n_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (!n_trial[32]) begin
                r_rem <= n_trial[31:0];
            end else begin
                r_rem <= n_shift[31:0];
            end
            r_quot <= {r_quot[30:0], ~n_trial[32]};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

FILE: rtl/smeu_datapath.sv
// ----------------------------------------------------------------------------
// smeu_datapath
// stack memory, stack pointer, operand registers, alu and result register
// ----------------------------------------------------------------------------
module smeu_datapath #(
    parameter int unsigned STACK_WORDS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smeu_pkg::t_in_item  i_item,
    input  smeu_pkg::t_ctl      i_ctl,
    output smeu_pkg::t_sts      o_sts,
    output smeu_pkg::t_out_item o_result
);
    import smeu_pkg::*;

    localparam int unsigned AddrW = (STACK_WORDS > 1) ? $clog2(STACK_WORDS) : 1;
    localparam int unsigned SpW   = $clog2(STACK_WORDS + 1);

    logic [DataW-1:0] r_mem [STACK_WORDS];
    logic [SpW-1:0]   r_sp;
    logic [4:0]       r_cmd;
    logic [31:0]      r_imm;
    logic [31:0]      r_top;
    logic [31:0]      r_sec;
    logic [31:0]      r_rd;
    logic [31:0]      r_res;
    logic [1:0]       r_status;
    logic             r_branch;
    logic             r_print;
    logic [31:0]      r_mul;
    logic             r_neg_q;
    logic             r_neg_r;

    logic [1:0]       n_need;
    logic             n_grow;
    logic [SpW-1:0]   n_rd_idx;
    logic             n_div;
    logic [31:0]      n_res;
    logic             n_branch;
    logic [31:0]      n_mtop;
    logic [31:0]      n_msec;
    logic             n_busy;
    logic [31:0]      n_quot;
    logic [31:0]      n_rem;
    logic             n_start;
    logic             n_ge_ts;
    logic             n_ge_st;

    always_comb begin
        n_need = 2'd0;
        n_grow = 1'b0;
        unique case (r_cmd)
            OP_PUSH: n_grow = 1'b1;
            OP_POP, OP_NOT, OP_PRINT: n_need = 2'd1;
            OP_DUP: begin
                n_need = 2'd1;
                n_grow = 1'b1;
            end
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_XOR, OP_OR,
            OP_AND, OP_SHR, OP_SHL, OP_JE, OP_JNE, OP_JGE, OP_JLE: n_need = 2'd2;
            default: ;
        endcase
    end

    assign n_div   = (r_cmd == OP_DIV) || (r_cmd == OP_MOD);
    assign n_mtop  = r_top[31] ? (32'd0 - r_top) : r_top;
    assign n_msec  = r_rd[31] ? (32'd0 - r_rd) : r_rd;
    assign n_ge_ts = $signed(r_top) >= $signed(r_sec);
    assign n_ge_st = $signed(r_sec) >= $signed(r_top);
    assign n_start = i_ctl.exec && n_div && r_status == ST_OK && r_rd != 32'd0;

    smeu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_start),
        .i_dividend (n_mtop),
        .i_divisor  (n_msec),
        .o_busy     (n_busy),
        .o_quot     (n_quot),
        .o_rem      (n_rem)
    );

    assign o_sts.div_busy = n_busy || n_start;

    always_comb begin
        n_rd_idx = r_sp - SpW'(1);
        if (i_ctl.rd_sec) begin
            n_rd_idx = r_sp - SpW'(2);
        end
    end

    // stack memory read port
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[n_rd_idx[AddrW-1:0]];
    end

    always_comb begin
        n_res    = r_top;
        n_branch = 1'b0;
        case (r_cmd)
            OP_ADD: n_res = r_top + r_sec;
            OP_SUB: n_res = r_top - r_sec;
            OP_MUL: n_res = r_mul;
            OP_DIV: n_res = r_neg_q ? (32'd0 - n_quot) : n_quot;
            OP_MOD: n_res = r_neg_r ? (32'd0 - n_rem) : n_rem;
            OP_XOR: n_res = r_top ^ r_sec;
            OP_OR:  n_res = r_top | r_sec;
            OP_AND: n_res = r_top & r_sec;
            OP_NOT: n_res = ~r_top;
            OP_SHR: n_res = 32'($signed(r_sec) >>> r_top[4:0]);
            OP_SHL: n_res = r_sec << r_top[4:0];
            OP_PUSH: n_res = r_imm;
            OP_SWAP: n_res = r_sec;
            OP_JMP: n_branch = 1'b1;
            OP_JE:  n_branch = r_top == r_sec;
            OP_JNE: n_branch = r_top != r_sec;
            OP_JGE: n_branch = n_ge_ts;
            OP_JLE: n_branch = n_ge_st;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_item.cmd;
            r_imm <= i_item.immediate;
        end
        // first read arrives in the cycle after rd_top
        if (i_ctl.rd_sec) begin
            r_top <= r_rd;
        end
        if (i_ctl.exec) begin
            r_sec <= r_rd;
        end
        r_mul   <= r_top * r_sec;
        r_neg_q <= r_top[31] ^ r_sec[31];
        r_neg_r <= r_top[31];
    end

    // status is set while the top entry is read, and set to divz at exec on a zero divisor
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_top) begin
            r_status <= ST_OK;
            if (r_sp < SpW'(n_need)) begin
                r_status <= ST_UNDER;
            end else if (n_grow && r_sp >= SpW'(STACK_WORDS)) begin
                r_status <= ST_OVER;
            end
        end else if (i_ctl.exec) begin
            if (r_status == ST_OK && n_div && r_rd == 32'd0) begin
                r_status <= ST_DIVZ;
            end
        end
    end

    // writeback
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && r_status == ST_OK) begin
            case (r_cmd)
                OP_PUSH, OP_DUP: r_mem[r_sp[AddrW-1:0]] <= n_res;
                OP_SWAP: r_mem[AddrW'(r_sp - SpW'(1))] <= r_sec;
                OP_NOT:  r_mem[AddrW'(r_sp - SpW'(1))] <= n_res;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_XOR, OP_OR, OP_AND,
                OP_SHR, OP_SHL: r_mem[AddrW'(r_sp - SpW'(2))] <= n_res;
                default: ;
            endcase
        end
        if (i_ctl.exec && r_status == ST_OK && r_cmd == OP_SWAP) begin
            r_mem[AddrW'(r_sp - SpW'(2))] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_ctl.commit && r_status == ST_OK) begin
            case (r_cmd)
                OP_PUSH, OP_DUP: r_sp <= r_sp + SpW'(1);
                OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_XOR, OP_OR,
                OP_AND, OP_SHR, OP_SHL: r_sp <= r_sp - SpW'(1);
                default: ;
            endcase
        end
    end

    // top after the step, kept alongside the pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_branch <= 1'b0;
            r_print  <= 1'b0;
            r_res    <= r_top;
            if (r_status == ST_OK) begin
                r_branch <= n_branch;
                r_print  <= r_cmd == OP_PRINT;
                case (r_cmd)
                    OP_PUSH, OP_DUP, OP_SWAP, OP_NOT, OP_ADD, OP_SUB, OP_MUL,
                    OP_DIV, OP_MOD, OP_XOR, OP_OR, OP_AND, OP_SHR,
                    OP_SHL: r_res <= n_res;
                    OP_POP: r_res <= r_sec;
                    default: ;
                endcase
            end
        end
    end

    logic [SpW-1:0] n_cnt;
    assign n_cnt = r_sp;

    always_comb begin
        o_result.top_value     = (n_cnt == '0) ? 32'sd0 : r_res;
        o_result.stack_count   = CountW'(n_cnt);
        o_result.branch_taken  = r_branch;
        o_result.print_request = r_print;
        o_result.status        = r_status;
    end
endmodule

FILE: rtl/smeu_ctrl.sv
// ----------------------------------------------------------------------------
// smeu_ctrl
// instruction sequencer and output handshake
// ----------------------------------------------------------------------------
module smeu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  smeu_pkg::t_sts i_sts,
    output smeu_pkg::t_ctl o_ctl
);
    import smeu_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RT   = 7'b0000010,
        S_RS   = 7'b0000100,
        S_EX   = 7'b0001000,
        S_WAIT = 7'b0010000,
        S_CM   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   n_accept;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_state == S_OUT;
    assign n_accept    = i_in_valid && r_state == S_IDLE;

    always_comb begin
        n_state      = r_state;
        o_ctl        = '0;
        o_ctl.load   = n_accept;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RT;
            S_RT: begin
                o_ctl.rd_top = 1'b1;
                n_state      = S_RS;
            end
            S_RS: begin
                o_ctl.rd_sec = 1'b1;
                n_state      = S_EX;
            end
            S_EX: begin
                o_ctl.exec = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: if (!i_sts.div_busy) n_state = S_CM;
            S_CM: begin
                o_ctl.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
